// File: rtl/utf8_to_codepoint_decoder_unit_macros.svh
// assertion macros for the utf-8 decoder unit
// no dependencies; included by the top level only
`ifndef UTF8_TO_CODEPOINT_DECODER_UNIT_MACROS_SVH
`define UTF8_TO_CODEPOINT_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8d_pkg.sv
// shared types and constants for the utf-8 decoder unit
// no dependencies
package u8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 16;

    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;
    localparam logic [7:0] PAYLOAD6    = 8'h3F;
    localparam logic [7:0] PAYLOAD5    = 8'h1F;
    localparam logic [7:0] PAYLOAD4    = 8'h0F;
    localparam logic [7:0] PAYLOAD3    = 8'h07;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         pending;
        logic [CP_W-1:0]    partial;
        logic               seq_bad;
        logic [COUNT_W-1:0] count;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               has_char;
        logic               malformed;
        logic               end_of_string;
        logic [COUNT_W-1:0] char_count;
    } dec_result_t;

endpackage

// File: rtl/utf8_to_codepoint_decoder_unit.sv
// utf-8 to code point decoder, top level: input register, decode step, result register
// depends on u8d_pkg, u8d_decode and utf8_to_codepoint_decoder_unit_macros.svh
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  input    | in_valid / in_stall  | byte_in, last_byte
//  result   | out_valid / out_stall| code_point, has_char, malformed, end_of_string,
//           |                      | char_count
//  config   | cfg_write_enable     | cfg_write_data (output_limit)
//
//  one byte per cycle sustained while the result channel is not stalled; a byte's result
//  is loaded into the result register as the byte leaves the input register
//  the sequence state register advances as a byte leaves the input register
//  reset clears handshake state and the sequence state and sets the limit to 65535
//  a stalled result only holds back bytes that would produce a result; bytes that
//  only extend a sequence pass through
`include "utf8_to_codepoint_decoder_unit_macros.svh"

module utf8_to_codepoint_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write_enable,
    input  logic [15:0]                 cfg_write_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  byte_in,
    input  logic                        last_byte,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u8d_pkg::CP_W-1:0]    code_point,
    output logic                        has_char,
    output logic                        malformed,
    output logic                        end_of_string,
    output logic [u8d_pkg::COUNT_W-1:0] char_count
);

    // configuration
    logic [u8d_pkg::COUNT_W-1:0] limit_reg;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // sequence state
    u8d_pkg::dec_state_t  state_reg;
    u8d_pkg::dec_state_t  state_next;

    // result register
    logic                 out_vld_reg;
    u8d_pkg::dec_result_t out_reg;

    u8d_pkg::dec_result_t step_result;
    logic                 step_has_result;
    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    u8d_decode u_decode (
        .state        (state_reg),
        .byte_val     (in_byte_reg),
        .last         (in_last_reg),
        .limit        (limit_reg),
        .state_next   (state_next),
        .result       (step_result),
        .result_valid (step_has_result)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_vld_reg || !out_stall;
    // decode the held byte unless its result has nowhere to go
    assign advance  = in_vld_reg && (!step_has_result || out_free);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= u8d_pkg::LIMIT_RESET;
        end
        else if (cfg_write_enable)
        begin
            limit_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_in;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && step_has_result)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_has_result)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid     = out_vld_reg;
    assign code_point    = out_reg.code_point;
    assign has_char      = out_reg.has_char;
    assign malformed     = out_reg.malformed;
    assign end_of_string = out_reg.end_of_string;
    assign char_count    = out_reg.char_count;

    // a closing result without a character carries no code point and no flag
    `U8D_ASSERT_NOW(a_empty_close, clk, rst_n, out_valid && !has_char,
        (code_point == '0) && !malformed, "result without character has payload")

    // a malformed result is a zero character
    `U8D_ASSERT_NOW(a_malformed_zero, clk, rst_n, out_valid && malformed,
        has_char && (code_point == '0), "malformed result not zero")

    // end of string returns the sequence state to zero
    `U8D_ASSERT_NEXT(a_string_clear, clk, rst_n, advance && in_last_reg,
        state_reg == '0, "state not cleared after end of string")

    // a result is only produced alongside a string end or a character
    `U8D_ASSERT_NOW(a_result_kind, clk, rst_n, out_valid,
        has_char || end_of_string, "result with neither character nor end")

endmodule

// File: rtl/u8d_decode.sv
// combinational decode step: one byte against the sequence state
// depends on u8d_pkg
module u8d_decode (
    input  u8d_pkg::dec_state_t           state,
    input  logic [7:0]                    byte_val,
    input  logic                          last,
    input  logic [u8d_pkg::COUNT_W-1:0]   limit,
    output u8d_pkg::dec_state_t           state_next,
    output u8d_pkg::dec_result_t          result,
    output logic                          result_valid
);

    logic                       have;
    logic                       bad;
    logic [u8d_pkg::CP_W-1:0]   cp;
    logic                       emit;
    u8d_pkg::dec_state_t        st;

    always_comb
    begin
        st   = state;
        have = 1'b0;
        bad  = 1'b0;
        cp   = '0;

        if (state.pending != u8d_pkg::PEND_NONE)
        begin
            // continuation slot: any byte is consumed, low six bits shifted in
            if ((byte_val & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_TAG)
            begin
                st.seq_bad = 1'b1;
            end
            st.partial = {state.partial[u8d_pkg::CP_W-7:0], byte_val[5:0]};
            st.pending = state.pending - 2'd1;
            if (st.pending == u8d_pkg::PEND_NONE)
            begin
                have = 1'b1;
                bad  = st.seq_bad;
                cp   = st.seq_bad ? '0 : st.partial;
            end
        end
        else if (!byte_val[7])
        begin
            have = 1'b1;
            cp   = {{(u8d_pkg::CP_W-8){1'b0}}, byte_val};
        end
        else if ((byte_val & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_TAG)
        begin
            st.pending = u8d_pkg::PEND_ONE;
            st.partial = {{(u8d_pkg::CP_W-8){1'b0}}, byte_val & u8d_pkg::PAYLOAD5};
            st.seq_bad = 1'b0;
        end
        else if ((byte_val & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_TAG)
        begin
            st.pending = u8d_pkg::PEND_TWO;
            st.partial = {{(u8d_pkg::CP_W-8){1'b0}}, byte_val & u8d_pkg::PAYLOAD4};
            st.seq_bad = 1'b0;
        end
        else if ((byte_val & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_TAG)
        begin
            st.pending = u8d_pkg::PEND_THREE;
            st.partial = {{(u8d_pkg::CP_W-8){1'b0}}, byte_val & u8d_pkg::PAYLOAD3};
            st.seq_bad = 1'b0;
        end
        else
        begin
            // stray continuation or f8..ff
            have = 1'b1;
            bad  = 1'b1;
        end

        // sequence cut off by end of string
        if (last && (st.pending != u8d_pkg::PEND_NONE))
        begin
            have       = 1'b1;
            bad        = 1'b1;
            cp         = '0;
            st.pending = u8d_pkg::PEND_NONE;
        end

        emit = have && (state.count < limit);
        if (emit)
        begin
            st.count = state.count + 16'd1;
        end

        result.code_point    = emit ? cp : '0;
        result.has_char      = emit;
        result.malformed     = emit && bad;
        result.end_of_string = last;
        result.char_count    = st.count;
        result_valid         = emit || last;

        state_next = last ? '0 : st;
    end

endmodule
